// ----- rtl/dgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dgt_pkg;
    localparam int REG_GRID_WIDTH   = 0;
    localparam int REG_GRID_HEIGHT  = 1;
    localparam int REG_ACC_LIMIT    = 2;
    localparam int REG_MAX_DISP     = 3;
    localparam int REG_JUMP_LIMIT   = 4;
    localparam int REG_DEPTH_LEVELS = 5;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_ACCURACY = 2'd1;
    localparam logic [1:0] ST_OFF_GRID = 2'd2;
    localparam logic [1:0] ST_NO_IDS   = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CELL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [8:0]  col;
        logic [8:0]  row;
        logic signed [15:0] x_disparity;
        logic [15:0] accuracy;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  status;
        logic [19:0] vertex_id;
        logic [15:0] level;
        logic [19:0] face_center;
        logic [19:0] face_first;
        logic [19:0] face_second;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_WRITE, S_RD_C, S_RD_L, S_RD_UL, S_RD_U, S_EVAL,
        S_EMIT0, S_EMIT1, S_STATUS
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/depth_grid_triangulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | direction | payload
// i_in    | in        | t_in_item  (kind, col, row, x_disparity, accuracy)
// o_out   | out       | t_out_item (one load status or one triangle; up to two per cell)
// i_cfg   | in        | t_cfg_item (register index, data)
// A stored load runs the restoring divider: a start step, the quotient-bit steps
// and a done step, then the write state, which registers the result; only after
// it is the next transfer taken. Rejected loads pass through a single status state.
// A cell on the grid runs four sequential reads of the single read port of the
// grid store, one evaluate state and two emit states, triangles or not.
// An off-grid cell is taken and dropped with no result.
// After reset a clearing pass sweeps every cell of the valid memory; no input
// transfer is taken meanwhile. Config writes are always taken.
// Output is a holding register; a stall holds the write, status or emit state.
module depth_grid_triangulator #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512,
    parameter int ID_BITS     = 20,
    parameter int LEVEL_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire dgt_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output dgt_pkg::t_out_item        o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire dgt_pkg::t_cfg_item   i_cfg_data
);
    import dgt_pkg::*;

    localparam int CB = $clog2(MAX_COLUMNS);
    localparam int RB = $clog2(MAX_ROWS);
    localparam int AB = CB + RB;

    // configuration
    logic [9:0]  r_gw, r_gh;
    logic [15:0] r_acc, r_mdis, r_jump, r_dlev;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 10'd512; r_gh <= 10'd512; r_acc <= 16'hFFFF;
            r_mdis <= 16'd255; r_jump <= 16'hFFFF; r_dlev <= 16'd255;
        end else if (i_cfg_valid) begin
            case (i_cfg_data.index)
                3'(REG_GRID_WIDTH):   r_gw   <= i_cfg_data.data[9:0];
                3'(REG_GRID_HEIGHT):  r_gh   <= i_cfg_data.data[9:0];
                3'(REG_ACC_LIMIT):    r_acc  <= i_cfg_data.data;
                3'(REG_MAX_DISP):     r_mdis <= i_cfg_data.data;
                3'(REG_JUMP_LIMIT):   r_jump <= i_cfg_data.data;
                3'(REG_DEPTH_LEVELS): r_dlev <= i_cfg_data.data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // effective grid size (as 13-bit values to compare against 9-bit positions)
    logic [12:0] w_eff, h_eff;
    assign w_eff = (13'(r_gw) < 13'(MAX_COLUMNS)) ? 13'(r_gw) : 13'(MAX_COLUMNS);
    assign h_eff = (13'(r_gh) < 13'(MAX_ROWS))    ? 13'(r_gh) : 13'(MAX_ROWS);

    t_state r_st, n_st;
    t_in_item r_item;
    logic [ID_BITS:0] r_nid;
    logic [15:0] r_mag;
    logic r_ok0, r_ok1;
    logic r_lv, r_ulv;
    logic [ID_BITS-1:0] r_cid, r_lid, r_ulid, r_uid;
    logic [LEVEL_BITS-1:0] r_clev, r_llev, r_ullev;
    logic r_ovalid, n_ovalid;
    t_out_item r_out, n_out;
    logic [1:0] r_stat;
    logic r_dstart;

    logic on_grid;
    assign on_grid = (13'(i_in_data.col) < w_eff) && (13'(i_in_data.row) < h_eff);
    logic r_on;  // centre cell holds a stored point
    logic r_lon, r_upon;  // left / up neighbour in range

    // store
    logic s_we, s_rv, s_clr;
    logic [AB-1:0] s_waddr, s_raddr;
    logic [ID_BITS-1:0] s_rid;
    logic [LEVEL_BITS-1:0] s_rlev, w_lev;
    logic [CB-1:0] c_c, c_l;
    logic [RB-1:0] r_r, r_u;
    assign c_c = CB'(r_item.col);
    assign c_l = CB'(r_item.col - 9'd1);
    assign r_r = RB'(r_item.row);
    assign r_u = RB'(r_item.row - 9'd1);

    dgt_store #(.ADDR_BITS(AB), .ID_BITS(ID_BITS), .LEVEL_BITS(LEVEL_BITS)) u_store (
        .i_clk, .i_rst_n, .i_we(s_we), .i_waddr(s_waddr), .i_wid(r_nid[ID_BITS-1:0]),
        .i_wlevel(w_lev), .i_raddr(s_raddr), .o_rvalid(s_rv), .o_rid(s_rid),
        .o_rlevel(s_rlev), .o_clearing(s_clr)
    );
    assign s_waddr = {r_r, c_c};

    // divider: q = depth_levels * |xd| / max(max_disparity,1)
    logic d_start, d_busy;
    logic [31:0] d_q;
    dgt_divider u_div (
        .i_clk, .i_rst_n, .i_start(d_start), .i_num(32'(r_dlev) * 32'(r_mag)),
        .i_den((r_mdis == 16'd0) ? 16'd1 : r_mdis), .o_busy(d_busy), .o_quot(d_q)
    );
    logic [31:0] lv_full;
    assign lv_full = (d_q >= 32'(r_dlev)) ? 32'd0 : 32'(r_dlev) - d_q;
    localparam logic [31:0] LMAX = 32'((64'd1 << LEVEL_BITS) - 64'd1);
    assign w_lev = LEVEL_BITS'((lv_full > LMAX) ? LMAX : lv_full);

    function automatic logic diff_ok(input logic [LEVEL_BITS-1:0] a,
                                     input logic [LEVEL_BITS-1:0] b,
                                     input logic [15:0] lim);
        logic [LEVEL_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        return 33'(d) <= 33'(lim);
    endfunction

    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_in_valid && !s_clr) begin
                if (i_in_data.kind == KIND_LOAD) begin
                    if (i_in_data.accuracy > r_acc || !on_grid ||
                        r_nid[ID_BITS]) n_st = S_STATUS;
                    else n_st = S_DIV;
                end else begin
                    n_st = on_grid ? S_RD_C : S_IDLE;
                end
            end
            S_DIV:    if (!d_busy) n_st = S_WRITE;
            S_WRITE:  if (out_free) n_st = S_IDLE;
            S_STATUS: if (out_free) n_st = S_IDLE;
            S_RD_C:   n_st = S_RD_L;
            S_RD_L:   n_st = S_RD_UL;
            S_RD_UL:  n_st = S_RD_U;
            S_RD_U:   n_st = S_EVAL;
            S_EVAL:   n_st = S_EMIT0;
            S_EMIT0:  if (out_free) n_st = S_EMIT1;
            S_EMIT1:  if (out_free) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // outputs / strobes
    always_comb begin
        o_in_ready = (r_st == S_IDLE) && !s_clr;
        s_we       = 1'b0;
        s_raddr    = {r_r, c_c};
        case (r_st)
            S_RD_L:  s_raddr = {r_r, c_l};
            S_RD_UL: s_raddr = {r_u, c_l};
            S_RD_U:  s_raddr = {r_u, c_c};
            S_WRITE: s_we = out_free;
            default: ;
        endcase
        d_start = (r_st == S_DIV) && r_dstart;
    end

    // next result and its valid flag
    always_comb begin
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = '0;
        n_out.last = 1'b1;
        case (r_st)
            S_WRITE: begin
                if (out_free) n_ovalid = 1'b1;
                n_out.status    = ST_STORED;
                n_out.vertex_id = 20'(r_nid[ID_BITS-1:0]);
                n_out.level     = 16'(w_lev);
            end
            S_STATUS: begin
                if (out_free) n_ovalid = 1'b1;
                n_out.status = r_stat;
            end
            S_EMIT0: begin
                if (out_free && r_ok0) n_ovalid = 1'b1;
                n_out.result_kind = 1'b1;
                n_out.face_center = 20'(r_cid);
                n_out.face_first  = 20'(r_lid);
                n_out.face_second = 20'(r_ulid);
                n_out.last        = !r_ok1;
            end
            S_EMIT1: begin
                if (out_free && r_ok1) n_ovalid = 1'b1;
                n_out.result_kind = 1'b1;
                n_out.face_center = 20'(r_cid);
                n_out.face_first  = 20'(r_ulid);
                n_out.face_second = 20'(r_uid);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_nid <= '0; r_ovalid <= 1'b0; r_dstart <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_dstart <= (r_st == S_IDLE) && i_in_valid && !s_clr;
            r_ovalid <= n_ovalid;
            if (r_st == S_WRITE && out_free) r_nid <= r_nid + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_item <= i_in_data;
                r_mag  <= i_in_data.x_disparity[15] ? 16'(-i_in_data.x_disparity)
                                                    : i_in_data.x_disparity;
                r_lon  <= i_in_data.col != 9'd0;
                r_upon <= i_in_data.row != 9'd0;
                r_stat <= (i_in_data.accuracy > r_acc) ? ST_ACCURACY :
                          !on_grid ? ST_OFF_GRID : ST_NO_IDS;
            end
            S_RD_L:  begin r_on <= s_rv; r_cid <= s_rid; r_clev <= s_rlev; end
            S_RD_UL: begin r_lv <= s_rv & r_lon; r_lid <= s_rid; r_llev <= s_rlev; end
            S_RD_U:  begin r_ulv <= s_rv & r_lon & r_upon; r_ulid <= s_rid;
                           r_ullev <= s_rlev; end
            S_EVAL:  begin
                r_uid <= s_rid;
                r_ok0 <= r_on && r_lv && r_ulv && diff_ok(r_llev, r_clev, r_jump) &&
                         diff_ok(r_ullev, r_clev, r_jump);
                r_ok1 <= r_on && r_ulv && s_rv && r_upon &&
                         diff_ok(r_ullev, r_clev, r_jump) && diff_ok(s_rlev, r_clev, r_jump);
            end
            S_WRITE, S_STATUS, S_EMIT0, S_EMIT1: if (out_free) r_out <= n_out;
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- rtl/dgt_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. 32-bit dividend, 16-bit divisor.
module dgt_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_quot
);
    logic [31:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic [16:0] t_sh;

    always_comb begin
        t_sh  = {r_rem[15:0], r_q[31]};
        n_q   = {r_q[30:0], 1'b0};
        n_rem = t_sh;
        if (t_sh >= {1'b0, r_den}) begin
            n_rem = t_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != 0) begin
            r_cnt <= r_cnt - 6'd1;
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 0) || i_start;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ----- rtl/dgt_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Grid store: valid, id and level per cell. One write, one read, registered read.
// Valid bits live in a separate memory swept clear after reset.
module dgt_store #(
    parameter int ADDR_BITS  = 18,
    parameter int ID_BITS    = 20,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [ADDR_BITS-1:0]  i_waddr,
    input  wire logic [ID_BITS-1:0]    i_wid,
    input  wire logic [LEVEL_BITS-1:0] i_wlevel,
    input  wire logic [ADDR_BITS-1:0]  i_raddr,
    output logic                       o_rvalid,
    output logic [ID_BITS-1:0]         o_rid,
    output logic [LEVEL_BITS-1:0]      o_rlevel,
    output logic                       o_clearing
);
    localparam int DEPTH = 1 << ADDR_BITS;
    logic                            mem_v [DEPTH];
    logic [ID_BITS+LEVEL_BITS-1:0]   mem_d [DEPTH];
    logic [ADDR_BITS:0]              r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (!r_clr[ADDR_BITS]) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr[ADDR_BITS] || !i_rst_n) begin
            mem_v[r_clr[ADDR_BITS-1:0]] <= 1'b0;
        end else if (i_we) begin
            mem_v[i_waddr] <= 1'b1;
        end
        if (i_we) begin
            mem_d[i_waddr] <= {i_wid, i_wlevel};
        end
        o_rvalid <= mem_v[i_raddr];
        {o_rid, o_rlevel} <= mem_d[i_raddr];
    end

    assign o_clearing = !r_clr[ADDR_BITS];
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import dgt_pkg::*;

    localparam int COLS = 512;
    localparam int ROWS = 512;
    localparam int SETTLE_CYCLES = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    t_cfg_item cfg_data = '0;

    always #5 clk = ~clk;

    depth_grid_triangulator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // ---- grid model: mirror of the block's store and registers ----
    bit        grid_valid [COLS*ROWS];
    bit [19:0] grid_id    [COLS*ROWS];
    bit [15:0] grid_lvl   [COLS*ROWS];
    longint    next_id = 0;
    int        width_reg = 512, height_reg = 512;
    int        acc_limit = 65535, max_disp = 255, jump_limit = 65535, depth_lvls = 255;

    t_in_item  pending_items [$];   // stimulus waiting for the driver
    t_out_item expected_out  [$];   // predicted results, oldest first
    int        n_queued = 0;
    int        n_taken = 0;
    int        n_errors = 0;
    bit        no_gaps = 1'b0;      // set for back-to-back stretches

    function automatic int eff_w();
        return width_reg < COLS ? width_reg : COLS;
    endfunction

    function automatic int eff_h();
        return height_reg < ROWS ? height_reg : ROWS;
    endfunction

    function automatic bit on_grid(int c, int r);
        return c >= 0 && r >= 0 && c < eff_w() && r < eff_h();
    endfunction

    function automatic bit near_ok(int c, int r, int lvl);
        int d;
        if (!on_grid(c, r) || !grid_valid[r*COLS + c])
            return 1'b0;
        d = int'(grid_lvl[r*COLS + c]) - lvl;
        if (d < 0)
            d = -d;
        return d <= jump_limit;
    endfunction

    // Works out the results one accepted item causes and updates the mirror.
    task automatic predict_results(input t_in_item it);
        t_out_item r;
        int        c, ctr, mag, divisor, lvl;
        longint    q;
        bit        tri_left, tri_up;
        c = it.col;
        r = '0;
        r.last = 1'b1;
        if (it.kind == KIND_LOAD) begin
            r.result_kind = KIND_LOAD;
            // accuracy test first, then grid, then id space
            if (int'(it.accuracy) > acc_limit) begin
                r.status = ST_ACCURACY;
            end else if (!on_grid(c, it.row)) begin
                r.status = ST_OFF_GRID;
            end else if (next_id >= (64'd1 << 20)) begin
                r.status = ST_NO_IDS;
            end else begin
                mag = it.x_disparity < 0 ? -int'(it.x_disparity) : int'(it.x_disparity);
                divisor = max_disp == 0 ? 1 : max_disp;
                q = (longint'(depth_lvls) * mag) / divisor;
                lvl = q >= depth_lvls ? 0 : depth_lvls - int'(q);
                ctr = it.row*COLS + c;
                grid_valid[ctr] = 1'b1;
                grid_id[ctr] = next_id[19:0];
                grid_lvl[ctr] = lvl[15:0];
                r.status = ST_STORED;
                r.vertex_id = next_id[19:0];
                r.level = lvl[15:0];
                next_id++;
            end
            expected_out.push_back(r);
        end else begin
            ctr = it.row*COLS + c;
            if (!on_grid(c, it.row) || !grid_valid[ctr])
                return;
            lvl = grid_lvl[ctr];
            tri_left = near_ok(c-1, it.row, lvl) && near_ok(c-1, it.row-1, lvl);
            tri_up   = near_ok(c-1, it.row-1, lvl) && near_ok(c, it.row-1, lvl);
            r.result_kind = KIND_CELL;
            r.face_center = grid_id[ctr];
            if (tri_left) begin
                r.face_first  = grid_id[ctr-1];
                r.face_second = grid_id[ctr-COLS-1];
                r.last = !tri_up;
                expected_out.push_back(r);
            end
            if (tri_up) begin
                r.face_first  = grid_id[ctr-COLS-1];
                r.face_second = grid_id[ctr-COLS];
                r.last = 1'b1;
                expected_out.push_back(r);
            end
        end
    endtask

    // ---- input driver: changes at the falling edge ----
    bit in_took = 1'b0;
    int in_gap = 0;

    always @(posedge clk) begin
        in_took <= in_valid && in_ready;
        if (in_valid && in_ready) begin
            predict_results(in_data);
            n_taken <= n_taken + 1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            in_valid <= 1'b1;                 // hold until transfer
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            in_data <= pending_items.pop_front();
            in_valid <= 1'b1;
            in_gap <= no_gaps ? 0 : $urandom_range(0, 12);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ---- output monitor and stall generator ----
    int out_stall = 0;

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        t_out_item e;
        if (out_valid && out_ready) begin
            out_stall <= no_gaps ? 0 : $urandom_range(0, 12);
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, out_data);
                n_errors++;
            end else begin
                e = expected_out.pop_front();
                check_field("result_kind", e.result_kind, out_data.result_kind);
                check_field("status", e.status, out_data.status);
                check_field("vertex_id", e.vertex_id, out_data.vertex_id);
                check_field("level", e.level, out_data.level);
                check_field("face_center", e.face_center, out_data.face_center);
                check_field("face_first", e.face_first, out_data.face_first);
                check_field("face_second", e.face_second, out_data.face_second);
                check_field("last", e.last, out_data.last);
            end
        end
    end

    always @(negedge clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n;
        end
    end

    // ---- stimulus helpers ----
    function automatic t_in_item point(int c, int r, int xd, int acc);
        t_in_item it;
        it.kind = KIND_LOAD;
        it.col = c[8:0];
        it.row = r[8:0];
        it.x_disparity = xd[15:0];
        it.accuracy = acc[15:0];
        return it;
    endfunction

    function automatic t_in_item cell_item(int c, int r);
        t_in_item it;
        it = point(c, r, $urandom, $urandom);  // load-only fields are don't-care
        it.kind = KIND_CELL;
        return it;
    endfunction

    task automatic queue_item(input t_in_item it);
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic write_reg(input int idx, input int val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data.index = idx[2:0];
        cfg_data.data = val[15:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GRID_WIDTH:   width_reg  = val & 'h3FF;
            REG_GRID_HEIGHT:  height_reg = val & 'h3FF;
            REG_ACC_LIMIT:    acc_limit  = val & 'hFFFF;
            REG_MAX_DISP:     max_disp   = val & 'hFFFF;
            REG_JUMP_LIMIT:   jump_limit = val & 'hFFFF;
            REG_DEPTH_LEVELS: depth_lvls = val & 'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Sender holds off until every transfer is done and every result has come;
    // cells that produce nothing may still be in flight, hence the settle time.
    task automatic drain();
        wait (n_taken == n_queued && expected_out.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input int w, input int h, input int acc, input int md,
                            input int jl, input int dl);
        drain();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_ACC_LIMIT, acc);
        write_reg(REG_MAX_DISP, md);
        write_reg(REG_JUMP_LIMIT, jl);
        write_reg(REG_DEPTH_LEVELS, dl);
    endtask

    // A patch of points, then the same cells scanned column-major.
    task automatic queue_patch();
        int w, h, c0, r0, pw, ph, base, spread;
        w = eff_w();
        h = eff_h();
        pw = $urandom_range(1, 6);
        ph = $urandom_range(1, 6);
        c0 = w > 0 ? $urandom_range(0, w - 1) : $urandom_range(0, 511);
        r0 = h > 0 ? $urandom_range(0, h - 1) : $urandom_range(0, 511);
        if ($urandom_range(0, 3) == 0) begin
            c0 = $urandom_range(0, 511);    // sometimes spill off the grid
            r0 = $urandom_range(0, 511);
        end
        base = $urandom_range(0, max_disp) * ($urandom_range(0, 1) ? 1 : -1);
        spread = $urandom_range(0, 1) ? 2 : 200;
        for (int c = c0; c < c0 + pw && c < 512; c++)
            for (int r = r0; r < r0 + ph && r < 512; r++)
                if ($urandom_range(0, 9) != 0)
                    queue_item(point(c, r,
                        $urandom_range(0, 15) == 0 ? int'($urandom) :
                            base + $urandom_range(0, spread) - spread/2,
                        $urandom_range(0, 7) == 0 ? int'($urandom) :
                            $urandom_range(0, acc_limit)));
        for (int c = c0; c < c0 + pw && c < 512; c++)
            for (int r = r0; r < r0 + ph && r < 512; r++)
                queue_item(cell_item(c, r));
    endtask

    task automatic random_phase(input int n_items);
        int          start;
        logic [63:0] raw;
        t_in_item    junk;
        start = n_queued;
        while (n_queued - start < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                raw = {$urandom, $urandom};
                junk = raw[$bits(t_in_item)-1:0];
                queue_item(junk);
            end else begin
                queue_patch();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, 512 x 512 grid
        queue_item(point(0, 0, 0, 0));           // zero disparity -> top level
        queue_item(point(1, 0, 255, 65535));     // full disparity, accuracy at limit
        queue_item(point(0, 1, -32768, 0));      // most negative disparity
        queue_item(point(1, 1, 32767, 100));
        queue_item(cell_item(1, 1));             // both triangles
        queue_item(cell_item(0, 0));             // corner: no neighbours
        queue_item(cell_item(5, 5));             // not stored
        queue_item(point(511, 511, -1, 1));
        queue_item(point(0, 0, 100, 0));         // reload with fresh id
        queue_item(cell_item(1, 1));
        queue_item(cell_item(511, 511));
        set_regs(0, 0, 0, 0, 0, 65535);          // zero grid, zero max disparity
        queue_item(point(3, 3, 5, 1));           // accuracy beats off grid
        queue_item(point(3, 3, 5, 0));           // off grid
        queue_item(cell_item(1, 1));             // off grid cell
        set_regs(1023, 1023, 65535, 0, 0, 65535);
        queue_item(point(1, 1, 0, 0));
        queue_item(point(2, 1, 0, 0));
        queue_item(point(1, 0, 0, 0));
        queue_item(point(2, 0, 1, 0));           // level gap with no slack
        queue_item(cell_item(2, 1));             // only the left triangle
        queue_item(point(300, 400, 65535, 0));

        // random phases across register settings
        set_regs(512, 512, 65535, 255, 65535, 255);
        random_phase(150);
        no_gaps = 1'b1;
        set_regs(1, 1, 40000, 1, 0, 0);
        random_phase(60);
        no_gaps = 1'b0;
        set_regs(20, 12, 60000, 65535, 3, 65535);
        random_phase(180);
        set_regs(512, 512, 0, 300, 10, 1000);
        random_phase(100);
        set_regs(1, 512, 65535, 40, 65535, 255);
        random_phase(80);
        set_regs(512, 1, 50000, 16, 4, 60);
        random_phase(80);
        no_gaps = 1'b1;
        set_regs(1023, 700, 65535, 255, 20, 255);
        random_phase(150);
        no_gaps = 1'b0;
        set_regs($urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(1000, 65535),
                 $urandom_range(1, 65535), $urandom_range(0, 100), $urandom_range(0, 65535));
        random_phase(250);

        drain();
        repeat (100) @(posedge clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog: the reset clearing pass and all phases must end before this time limit
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
